// ----- sv/q2e_pkg.sv -----
package q2e_pkg;

  localparam int Q_W         = 32;  // quaternion part width
  localparam int PROD_W      = 44;  // Q40 product, floor of Q60
  localparam int OP_W        = 50;  // CORDIC x/y datapath
  localparam int ANG_W       = 34;  // Q30 radian accumulator
  localparam int ROOT_W      = 31;  // isqrt result
  localparam int SQ_IN_W     = 62;  // isqrt radicand, 2 bits per cell
  localparam int REM_W       = 35;  // isqrt partial remainder
  localparam int OFS_W       = 13;
  localparam int PITCH_W     = 16;
  localparam int ROLL_W      = 17;
  localparam int YAW_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFS   = 2'd2;

  localparam logic signed [OFS_W-1:0] PITCH_OFS_RST = 13'sd256;
  localparam logic signed [OFS_W-1:0] ROLL_OFS_RST  = -13'sd512;
  localparam logic signed [OFS_W-1:0] YAW_OFS_RST   = 13'sd0;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [17:0] DEG_NUM   = 18'd146688;
  localparam logic [31:0] RECIP_10  = 32'hCCCCCCCD;  // 2^35 / 10, rounded up

  // arctangent of 2^-i, Q30 radians, truncated
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'h3243F6A8;
      5'd1:  v = 31'h1DAC6705;
      5'd2:  v = 31'h0FADBAFC;
      5'd3:  v = 31'h07F56EA6;
      5'd4:  v = 31'h03FEAB76;
      5'd5:  v = 31'h01FFD55B;
      5'd6:  v = 31'h00FFFAAA;
      5'd7:  v = 31'h007FFF55;
      5'd8:  v = 31'h003FFFEA;
      5'd9:  v = 31'h001FFFFD;
      5'd10: v = 31'h000FFFFF;
      5'd11: v = 31'h0007FFFF;
      5'd12: v = 31'h0003FFFF;
      5'd13: v = 31'h0001FFFF;
      5'd14: v = 31'h0000FFFF;
      5'd15: v = 31'h00007FFF;
      5'd16: v = 31'h00003FFF;
      5'd17: v = 31'h00001FFF;
      5'd18: v = 31'h00000FFF;
      5'd19: v = 31'h000007FF;
      5'd20: v = 31'h000003FF;
      5'd21: v = 31'h000001FF;
      5'd22: v = 31'h000000FF;
      5'd23: v = 31'h0000007F;
      5'd24: v = 31'h0000003F;
      5'd25: v = 31'h0000001F;
      5'd26: v = 31'h0000000F;
      5'd27: v = 31'h00000007;
      5'd28: v = 31'h00000003;
      5'd29: v = 31'h00000001;
      default: v = 31'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/q2e_if.sv -----
interface q2e_in_if;
  import q2e_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  quat_present;
  logic signed [Q_W-1:0] comp_w;
  logic signed [Q_W-1:0] comp_x;
  logic signed [Q_W-1:0] comp_y;
  logic signed [Q_W-1:0] comp_z;
  modport source(output valid, quat_present, comp_w, comp_x, comp_y, comp_z, input ready);
  modport sink(input valid, quat_present, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface q2e_out_if;
  import q2e_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [YAW_W-1:0]   yaw_angle;
  logic                      asin_clamped;
  modport source(output valid, pitch_angle, roll_angle, yaw_angle, asin_clamped,
                 input ready);
  modport sink(input valid, pitch_angle, roll_angle, yaw_angle, asin_clamped,
               output ready);
endinterface

// ----- sv/quaternion_to_euler_angles.sv -----
// Quaternion (Q30) to Z-Y-X Euler angles in degrees Q8, offset by three
// configurable registers. One word is taken every cycle while the result side
// keeps up; the whole pipeline holds while a finished result waits. Stages in
// order: products, sums and the sine square, the bit-per-cell square root that
// gives the pitch cosine, the quadrant pre-rotation, the three parallel CORDIC
// rows of CORDIC_STEPS cells, and degree scaling and offset. Words without a
// quaternion are taken and give no result.
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  q2e_in_if.sink               in_word,
  q2e_out_if.source            out_word,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0]     cfg_data
);

  localparam int SIDE_W = 1 + Q_W + 4*OP_W;
  localparam int NS     = CORDIC_STEPS;

  logic adv;
  assign adv           = !out_word.valid || out_word.ready;
  assign in_word.ready = adv;

  // configuration
  logic signed [OFS_W-1:0] ofs_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r[0] <= PITCH_OFS_RST;
      ofs_r[1] <= ROLL_OFS_RST;
      ofs_r[2] <= YAW_OFS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PITCH_OFS: ofs_r[0] <= cfg_data;
        REG_ROLL_OFS:  ofs_r[1] <= cfg_data;
        REG_YAW_OFS:   ofs_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: products
  logic                      p1_vld_r;
  logic signed [2*Q_W-1:0]   wy_r, xz_r, yz_r, wx_r, xx_r, yy_r, xy_r, wz_r, ww_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_word.valid && in_word.quat_present;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wy_r <= in_word.comp_w * in_word.comp_y;
      xz_r <= in_word.comp_x * in_word.comp_z;
      yz_r <= in_word.comp_y * in_word.comp_z;
      wx_r <= in_word.comp_w * in_word.comp_x;
      xx_r <= in_word.comp_x * in_word.comp_x;
      yy_r <= in_word.comp_y * in_word.comp_y;
      xy_r <= in_word.comp_x * in_word.comp_y;
      wz_r <= in_word.comp_w * in_word.comp_z;
      ww_r <= in_word.comp_w * in_word.comp_w;
      zz_r <= in_word.comp_z * in_word.comp_z;
    end
  end

  // stage 2: Q40 sums, sine clamp
  logic signed [PROD_W-1:0] q_wy, q_xz, q_yz, q_wx, q_xx, q_yy, q_xy, q_wz, q_ww, q_zz;
  logic signed [OP_W-1:0]   s40, s40c, rsy, rsx, ysy, ysx;
  logic                     clamp;
  localparam logic signed [OP_W-1:0] ONE_Q40 = OP_W'(64'sd1 <<< 40);

  always_comb begin
    q_wy = wy_r[2*Q_W-1:20];
    q_xz = xz_r[2*Q_W-1:20];
    q_yz = yz_r[2*Q_W-1:20];
    q_wx = wx_r[2*Q_W-1:20];
    q_xx = xx_r[2*Q_W-1:20];
    q_yy = yy_r[2*Q_W-1:20];
    q_xy = xy_r[2*Q_W-1:20];
    q_wz = wz_r[2*Q_W-1:20];
    q_ww = ww_r[2*Q_W-1:20];
    q_zz = zz_r[2*Q_W-1:20];
    s40  = (OP_W'(q_wy) - OP_W'(q_xz)) <<< 1;
    rsy  = (OP_W'(q_yz) + OP_W'(q_wx)) <<< 1;
    rsx  = ONE_Q40 - ((OP_W'(q_xx) + OP_W'(q_yy)) <<< 1);
    ysy  = (OP_W'(q_xy) + OP_W'(q_wz)) <<< 1;
    ysx  = OP_W'(q_ww) + OP_W'(q_xx) - OP_W'(q_yy) - OP_W'(q_zz);
    clamp = 1'b1;
    if (s40 > ONE_Q40)       s40c = ONE_Q40;
    else if (s40 < -ONE_Q40) s40c = -ONE_Q40;
    else begin
      s40c  = s40;
      clamp = 1'b0;
    end
  end

  logic                   p2_vld_r, p2_clamp_r;
  logic signed [Q_W-1:0]  p2_s30_r;
  logic signed [OP_W-1:0] p2_rsy_r, p2_rsx_r, p2_ysy_r, p2_ysx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_clamp_r <= clamp;
      p2_s30_r   <= Q_W'(s40c >>> 10);
      p2_rsy_r   <= rsy;
      p2_rsx_r   <= rsx;
      p2_ysy_r   <= ysy;
      p2_ysx_r   <= ysx;
    end
  end

  // stage 3: sine squared
  logic                     p3_vld_r;
  logic signed [2*Q_W-1:0]  p3_sq_r;
  logic [SIDE_W-1:0]        p3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_sq_r   <= p2_s30_r * p2_s30_r;
      p3_side_r <= {p2_clamp_r, p2_s30_r, p2_rsy_r, p2_rsx_r, p2_ysy_r, p2_ysx_r};
    end
  end

  // square root row: cosine = isqrt(2^60 - s^2)
  logic               sq_vld  [ROOT_W+1];
  logic [SQ_IN_W-1:0] sq_rad  [ROOT_W+1];
  logic [REM_W-1:0]   sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root [ROOT_W+1];
  logic [SIDE_W-1:0]  sq_side [ROOT_W+1];
  localparam logic [2*Q_W-1:0] ONE_Q60 = 64'd1 << 60;

  assign sq_vld[0]  = p3_vld_r;
  assign sq_rad[0]  = SQ_IN_W'(ONE_Q60 - p3_sq_r);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = p3_side_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    q2e_sqrt_cell #(.SIDE_W(SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sq_vld[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // pre-rotation into the right half-plane; lane 0 pitch, 1 roll, 2 yaw
  logic                   s_clamp;
  logic signed [Q_W-1:0]  s_s30;
  logic signed [OP_W-1:0] s_rsy, s_rsx, s_ysy, s_ysx;
  logic signed [OP_W-1:0] ax [3];
  logic signed [OP_W-1:0] ay [3];

  assign {s_clamp, s_s30, s_rsy, s_rsx, s_ysy, s_ysx} = sq_side[ROOT_W];
  assign ax[0] = OP_W'({1'b0, sq_root[ROOT_W]});
  assign ay[0] = OP_W'(s_s30);
  assign ax[1] = s_rsx;
  assign ay[1] = s_rsy;
  assign ax[2] = s_ysx;
  assign ay[2] = s_ysy;

  logic                    cvld   [NS+1];
  logic                    cclamp [NS+1];
  logic [2:0]              czero  [NS+1];
  logic signed [OP_W-1:0]  cx [3][NS+1];
  logic signed [OP_W-1:0]  cy [3][NS+1];
  logic signed [ANG_W-1:0] cz [3][NS+1];
  logic                    cvld_r, cclamp_r;
  logic [2:0]              czero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= 1'b0;
    end else if (adv) begin
      cvld_r <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cclamp_r <= s_clamp;
    end
  end

  assign cvld[0]   = cvld_r;
  assign cclamp[0] = cclamp_r;
  assign czero[0]  = czero_r;

  for (genvar l = 0; l < 3; l++) begin : g_pre
    logic signed [OP_W-1:0]  px_r, py_r;
    logic signed [ANG_W-1:0] pz_r;

    always_ff @(posedge clk) begin
      if (adv) begin
        czero_r[l] <= (ax[l] == '0) && (ay[l] == '0);
        if (ax[l][OP_W-1] && !ay[l][OP_W-1]) begin
          px_r <= ay[l];
          py_r <= -ax[l];
          pz_r <= HALF_PI_Q30;
        end else if (ax[l][OP_W-1]) begin
          px_r <= -ay[l];
          py_r <= ax[l];
          pz_r <= -HALF_PI_Q30;
        end else begin
          px_r <= ax[l];
          py_r <= ay[l];
          pz_r <= '0;
        end
      end
    end

    assign cx[l][0] = px_r;
    assign cy[l][0] = py_r;
    assign cz[l][0] = pz_r;

    for (genvar s = 0; s < NS; s++) begin : g_step
      q2e_cordic_cell #(.STEP(s)) u_cell (
        .clk (clk),
        .en  (adv),
        .x_i (cx[l][s]),
        .y_i (cy[l][s]),
        .z_i (cz[l][s]),
        .x_o (cx[l][s+1]),
        .y_o (cy[l][s+1]),
        .z_o (cz[l][s+1])
      );
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_flags
    logic       vld_r, clamp_r;
    logic [2:0] zero_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= cvld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        clamp_r <= cclamp[s];
        zero_r  <= czero[s];
      end
    end

    assign cvld[s+1]   = vld_r;
    assign cclamp[s+1] = clamp_r;
    assign czero[s+1]  = zero_r;
  end

  // degrees Q8: round(|z| * 146688 / (10 * 2^30)), then sign and offset
  logic        d1_vld_r, d2_vld_r, d1_clamp_r, d2_clamp_r;
  logic [2:0]  d1_neg_r, d2_neg_r;
  logic signed [19:0] ang [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
      d2_vld_r <= 1'b0;
    end else if (adv) begin
      d1_vld_r <= cvld[NS];
      d2_vld_r <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_clamp_r <= cclamp[NS];
      d2_clamp_r <= d1_clamp_r;
      d2_neg_r   <= d1_neg_r;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_deg
    logic signed [ANG_W-1:0] zf;
    logic [ANG_W-2:0]        mag;
    logic [50:0]             d1_prod_r;
    logic [52:0]             rnd;
    logic [53:0]             d2_prod_r;
    logic [18:0]             q;

    always_comb begin
      zf  = czero[NS][l] ? '0 : cz[l][NS];
      mag = zf[ANG_W-1] ? (ANG_W-1)'(-zf) : zf[ANG_W-2:0];
      rnd = 53'(d1_prod_r) + (53'd5 << 30);
      q   = d2_prod_r[53:35];
      ang[l] = d2_neg_r[l] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1_neg_r[l] <= zf[ANG_W-1];
        d1_prod_r   <= 51'(mag) * 51'(DEG_NUM);
        d2_prod_r   <= 54'(rnd[52:30]) * 54'(RECIP_10);
      end
    end
  end

  // result register
  logic                      out_vld_r, clamp_out_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [YAW_W-1:0]   yaw_r;
  logic signed [19:0]        sum [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sum[l] = ang[l] + 20'(ofs_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_r     <= sum[0][PITCH_W-1:0];
      roll_r      <= sum[1][ROLL_W-1:0];
      yaw_r       <= sum[2][YAW_W-1:0];
      clamp_out_r <= d2_clamp_r;
    end
  end

  assign out_word.valid        = out_vld_r;
  assign out_word.pitch_angle  = pitch_r;
  assign out_word.roll_angle   = roll_r;
  assign out_word.yaw_angle    = yaw_r;
  assign out_word.asin_clamped = clamp_out_r;

endmodule

// ----- sv/q2e_sqrt_cell.sv -----
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [SQ_IN_W-1:0] rad_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [SQ_IN_W-1:0] rad_o,
  output logic [REM_W-1:0]   rem_o,
  output logic [ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]  side_o
);

  logic               vld_r;
  logic [SQ_IN_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [SIDE_W-1:0]  side_r;

  // one root bit per cell: bring down the next two radicand bits
  always_comb begin
    rem_sh  = {rem_i[REM_W-3:0], rad_i[SQ_IN_W-1 -: 2]};
    trial   = REM_W'({root_i, 2'b01});
    rad_nxt = {rad_i[SQ_IN_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// ----- sv/q2e_cordic_cell.sv -----
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [OP_W-1:0]  x_i,
  input  logic signed [OP_W-1:0]  y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic signed [OP_W-1:0]  x_o,
  output logic signed [OP_W-1:0]  y_o,
  output logic signed [ANG_W-1:0] z_o
);

  localparam logic signed [ANG_W-1:0] ATAN =
    $signed({{(ANG_W-31){1'b0}}, atan_q30(5'(STEP))});

  logic signed [OP_W-1:0]  xs, ys, x_r, y_r, x_nxt, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!y_i[OP_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import q2e_pkg::*;

  localparam int CORDIC_ROWS = 24;
  localparam int PIPE_DEPTH = CORDIC_ROWS + 38;

  typedef struct {
    logic                      present;
    logic signed [Q_W-1:0]     w, x, y, z;
  } quat_word_t;

  typedef struct {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ROLL_W-1:0]  roll;
    logic signed [YAW_W-1:0]   yaw;
    logic                      clamped;
  } euler_word_t;

  class euler_board;
    euler_word_t        pending_angles[$];
    logic signed [12:0] pitch_ofs, roll_ofs, yaw_ofs;
    int                 errors;
    longint             atan_tab[24];

    function new();
      atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                   64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                   64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                   64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                   64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                   64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      pitch_ofs = 13'sd256;
      roll_ofs  = -13'sd512;
      yaw_ofs   = 13'sd0;
      errors    = 0;
    endfunction

    function void set_offset(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] val);
      case (idx)
        REG_PITCH_OFS: pitch_ofs = val;
        REG_ROLL_OFS:  roll_ofs = val;
        REG_YAW_OFS:   yaw_ofs = val;
        default: ;
      endcase
    endfunction

    function longint mul40(longint a, longint b);
      return (a * b) >>> 20;
    endfunction

    function longint root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(res);
    endfunction

    // vectoring rotation, Q30 radians out
    function longint angle_q30(longint ay, longint ax);
      longint ang, t, xs, ys;
      ang = 0;
      if (ax == 0 && ay == 0) return 0;
      if (ax < 0) begin
        if (ay >= 0) begin
          t = ax; ax = ay; ay = -t; ang = 1686629713;
        end else begin
          t = ax; ax = -ay; ay = t; ang = -1686629713;
        end
      end
      for (int i = 0; i < CORDIC_ROWS; i++) begin
        xs = ax >>> i;
        ys = ay >>> i;
        if (ay >= 0) begin
          ax += ys; ay -= xs; ang += atan_tab[i];
        end else begin
          ax -= ys; ay += xs; ang -= atan_tab[i];
        end
      end
      return ang;
    endfunction

    function longint deg_q8(longint ang);
      longint mag, q;
      mag = (ang < 0) ? -ang : ang;
      q = (mag * 146688 + 64'd5368709120) / 64'd10737418240;
      return (ang < 0) ? -q : q;
    endfunction

    function void note_word(quat_word_t q);
      euler_word_t e;
      longint w, x, y, z, s40, s30, sy, sx, p, r, yw;
      if (!q.present) return;
      w = q.w; x = q.x; y = q.y; z = q.z;
      e.clamped = 1'b0;
      s40 = 2 * (mul40(w, y) - mul40(x, z));
      if (s40 > (64'sd1 <<< 40)) begin
        s40 = 64'sd1 <<< 40; e.clamped = 1'b1;
      end else if (s40 < -(64'sd1 <<< 40)) begin
        s40 = -(64'sd1 <<< 40); e.clamped = 1'b1;
      end
      s30 = s40 >>> 10;
      p = deg_q8(angle_q30(s30, root_floor((64'd1 << 60) - s30 * s30)));
      sy = 2 * (mul40(y, z) + mul40(w, x));
      sx = (64'sd1 <<< 40) - 2 * (mul40(x, x) + mul40(y, y));
      r = deg_q8(angle_q30(sy, sx));
      sy = 2 * (mul40(x, y) + mul40(w, z));
      sx = mul40(w, w) + mul40(x, x) - mul40(y, y) - mul40(z, z);
      yw = deg_q8(angle_q30(sy, sx));
      e.pitch = PITCH_W'(p + pitch_ofs);
      e.roll  = ROLL_W'(r + roll_ofs);
      e.yaw   = YAW_W'(yw + yaw_ofs);
      pending_angles.push_back(e);
    endfunction

    function void check_word(euler_word_t got);
      euler_word_t exp_w;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected word pitch=%0d roll=%0d yaw=%0d clamp=%0b",
                 $time, got.pitch, got.roll, got.yaw, got.clamped);
        errors++;
        return;
      end
      exp_w = pending_angles.pop_front();
      if (got.pitch !== exp_w.pitch) begin
        $display("%0t: pitch exp %0d got %0d", $time, exp_w.pitch, got.pitch);
        errors++;
      end
      if (got.roll !== exp_w.roll) begin
        $display("%0t: roll exp %0d got %0d", $time, exp_w.roll, got.roll);
        errors++;
      end
      if (got.yaw !== exp_w.yaw) begin
        $display("%0t: yaw exp %0d got %0d", $time, exp_w.yaw, got.yaw);
        errors++;
      end
      if (got.clamped !== exp_w.clamped) begin
        $display("%0t: clamp exp %0b got %0b", $time, exp_w.clamped, got.clamped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFS_W-1:0] cfg_data = '0;

  q2e_in_if  in_word();
  q2e_out_if out_word();

  quaternion_to_euler_angles uut (
    .clk(clk), .rst_n(rst_n), .in_word(in_word.sink), .out_word(out_word.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  euler_board board = new();
  int  hold_left = 0;
  int  hold_req = 0;   // bumped by the stimulus to ask for a long hold-off
  int  hold_seen = 0;
  bit  rx_eager = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_word.valid = 1'b0;
    in_word.quat_present = 1'b0;
    in_word.comp_w = '0;
    in_word.comp_x = '0;
    in_word.comp_y = '0;
    in_word.comp_z = '0;
    out_word.ready = 1'b0;
  end

  initial begin
    #20ms;
    $display("[quaternion_to_euler_angles] ERROR");
    $finish;
  end

  // receiver: mostly ready, short and rare long stalls, always ready when eager, forced hold-off on request
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_req != hold_seen) begin
      out_word.ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= PIPE_DEPTH * 3 - 1;
    end else if (hold_left > 0) begin
      out_word.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_eager) begin
      out_word.ready <= 1'b1;
    end else if (r < 70) begin
      out_word.ready <= 1'b1;
    end else if (r < 98) begin
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= 1'b0;
      hold_left <= $urandom_range(10, 60);
    end
  end

  always @(posedge clk) begin
    quat_word_t q;
    euler_word_t e;
    if (rst_n && in_word.valid && in_word.ready) begin
      q.present = in_word.quat_present;
      q.w = in_word.comp_w; q.x = in_word.comp_x;
      q.y = in_word.comp_y; q.z = in_word.comp_z;
      board.note_word(q);
    end
    if (rst_n && out_word.valid && out_word.ready) begin
      e.pitch = out_word.pitch_angle;
      e.roll = out_word.roll_angle;
      e.yaw = out_word.yaw_angle;
      e.clamped = out_word.asin_clamped;
      board.check_word(e);
    end
  end

  task automatic send_quat(bit present, int w, int x, int y, int z, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_word.valid = 1'b0;
    end
    @(negedge clk);
    in_word.valid = 1'b1;
    in_word.quat_present = present;
    in_word.comp_w = w; in_word.comp_x = x;
    in_word.comp_y = y; in_word.comp_z = z;
    do @(posedge clk); while (!in_word.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_word.valid = 1'b0;
    while (board.pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1; cfg_index = idx; cfg_data = val;
    board.set_offset(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_random();
    int  kind, w, x, y, z;
    real a, b, c, d, n;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // unit quaternion with random direction
      a = $itor($urandom_range(0, 2000000)) - 1.0e6;
      b = $itor($urandom_range(0, 2000000)) - 1.0e6;
      c = $itor($urandom_range(0, 2000000)) - 1.0e6;
      d = $itor($urandom_range(0, 2000000)) - 1.0e6;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 1.0e6; n = 1.0e6;
      end
      w = $rtoi(a / n * 1073741824.0); x = $rtoi(b / n * 1073741824.0);
      y = $rtoi(c / n * 1073741824.0); z = $rtoi(d / n * 1073741824.0);
      send_quat(1'b1, w, x, y, z, pick_gap());
    end else if (kind < 80) begin
      send_quat(1'b1, $urandom, $urandom, $urandom, $urandom, pick_gap());
    end else if (kind < 90) begin
      send_quat(1'b1, $urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                $urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32, pick_gap());
    end else begin
      send_quat(1'b0, $urandom, $urandom, $urandom, $urandom, pick_gap());
    end
  endtask

  localparam int ONE = 1073741824;
  localparam int HALF = 759250125;  // 2^30 / sqrt(2)

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset offsets, directed words
    send_quat(1'b1, ONE, 0, 0, 0, 0);
    send_quat(1'b1, 0, 0, 0, 0, 0);
    send_quat(1'b1, -ONE, 0, 0, 0, 0);
    send_quat(1'b1, 0, ONE, 0, 0, 1);
    send_quat(1'b1, 0, 0, ONE, 0, 0);
    send_quat(1'b1, 0, 0, 0, ONE, 0);
    send_quat(1'b1, 0, 0, 0, -ONE, 0);
    send_quat(1'b1, HALF, 0, HALF, 0, 0);
    send_quat(1'b1, HALF, 0, -HALF, 0, 2);
    send_quat(1'b1, ONE, 0, ONE, 0, 0);
    send_quat(1'b1, ONE, ONE, -ONE, ONE, 0);
    send_quat(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_quat(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_quat(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    send_quat(1'b1, HALF, HALF, 0, 0, 0);
    send_quat(1'b1, HALF, 0, 0, -HALF, 0);
    send_quat(1'b1, 0, HALF, 0, -HALF, 0);
    send_quat(1'b1, -1, 1, -1, 1, 0);
    send_quat(1'b0, ONE, ONE, ONE, ONE, 0);
    send_quat(1'b0, 0, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PITCH_OFS, 13'h0FFF);
          write_reg(REG_ROLL_OFS, 13'h0FFF);
          write_reg(REG_YAW_OFS, 13'h0FFF);
        end
        1: begin
          write_reg(REG_PITCH_OFS, 13'h1000);
          write_reg(REG_ROLL_OFS, 13'h1000);
          write_reg(REG_YAW_OFS, 13'h1000);
          write_reg(2'd3, 13'h0ABC);  // unmapped index, no effect
        end
        default: begin
          write_reg(REG_PITCH_OFS, OFS_W'($urandom_range(0, 5120) - 2560));
          write_reg(REG_ROLL_OFS, OFS_W'($urandom_range(0, 5120) - 2560));
          write_reg(REG_YAW_OFS, OFS_W'($urandom_range(0, 5120) - 2560));
        end
      endcase
      rx_eager = (ph == 3);
      if (ph == 2) begin
        // receiver holds off long enough for the pipeline to back up
        @(negedge clk);
        hold_req++;
      end
      for (int i = 0; i < 265; i++) send_random();
      drain();
    end
    rx_eager = 1'b0;

    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (board.errors == 0 && board.pending_angles.size() == 0)
      $display("[quaternion_to_euler_angles] OK");
    else
      $display("[quaternion_to_euler_angles] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
sv/q2e_pkg.sv
sv/q2e_if.sv
sv/q2e_sqrt_cell.sv
sv/q2e_cordic_cell.sv
sv/quaternion_to_euler_angles.sv
test/tb_top.sv
